// ----- rtl/core/dispersal_distance_kernel_unit_defines.svh -----
// shared assertion macros
`ifndef DISPERSAL_DISTANCE_KERNEL_UNIT_DEFINES_SVH
`define DISPERSAL_DISTANCE_KERNEL_UNIT_DEFINES_SVH

// implication checked on every clock edge outside reset
`define DDK_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// implication checked at the next clock edge
`define DDK_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/core/ddk_pkg.sv -----
package ddk_pkg;

  localparam int RATIO_BITS_DEF     = 24;
  localparam int DIST_FRAC_BITS_DEF = 8;
  localparam int DIST_BITS          = 40;
  localparam int MODE_BITS          = 3;
  localparam int SCALE_BITS         = 16;
  localparam int CFG_DATA_BITS      = 16;
  localparam int CFG_INDEX_BITS     = 1;
  localparam int LOG_ROUNDS         = 30;
  localparam int EXP_ROUNDS         = 30;

  localparam logic [MODE_BITS-1:0] MODE_LINEAR = 3'd0;
  localparam logic [MODE_BITS-1:0] MODE_EXP    = 3'd1;
  localparam logic [MODE_BITS-1:0] MODE_FAT    = 3'd2;
  localparam logic [MODE_BITS-1:0] MODE_GAUSS  = 3'd3;
  localparam logic [MODE_BITS-1:0] MODE_COMB   = 3'd4;

  localparam logic [CFG_INDEX_BITS-1:0] REG_MODE  = 1'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_SCALE = 1'd1;

  localparam logic [SCALE_BITS-1:0] SCALE_RESET = 16'd256;
  localparam logic [29:0] LN2_Q28 = 30'd186065279;

  // reciprocal of 19, exact for quotients below 2^24
  localparam logic [27:0] RECIP19       = 28'd226050911;
  localparam int          RECIP19_SHIFT = 32;

  function automatic logic [63:0] isqrt64(input logic [63:0] x);
    logic [63:0] v;
    logic [63:0] res;
    logic [63:0] bt;
    begin
      v = x;
      res = '0;
      bt = 64'(1) << 62;
      for (int k = 0; k < 32; k++) begin
        if (v >= res + bt) begin
          v = v - (res + bt);
          res = (res >> 1) + bt;
        end else begin
          res = res >> 1;
        end
        bt = bt >> 2;
      end
      return res;
    end
  endfunction

  // 2^(2^-i) in Q1.30 by the truncating sqrt chain, entry i-1 holds round i
  function automatic logic [EXP_ROUNDS*32-1:0] exp2_roots();
    logic [EXP_ROUNDS*32-1:0] v;
    logic [63:0] c;
    begin
      v = '0;
      c = 64'(1) << 31;
      for (int i = 1; i <= EXP_ROUNDS; i++) begin
        c = isqrt64(c << 30);
        v[(i-1)*32 +: 32] = c[31:0];
      end
      return v;
    end
  endfunction

endpackage

// ----- rtl/core/dispersal_distance_kernel_unit.sv -----
// path: from input transfer through the NS pipeline stages and the output register to result valid
// throughput: one item per cycle; the pipeline advances whenever the output slot is free
// each log and exp round holds one narrow multiply in its own stage
// reset (rst, synchronous): clears pipeline valid bits, mode to linear, scale to 1.0
`include "dispersal_distance_kernel_unit_defines.svh"

module dispersal_distance_kernel_unit #(
  parameter int RATIO_BITS     = ddk_pkg::RATIO_BITS_DEF,
  parameter int DIST_FRAC_BITS = ddk_pkg::DIST_FRAC_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [ddk_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [ddk_pkg::CFG_DATA_BITS-1:0] cfg_data,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [RATIO_BITS-1:0]             ratio,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [ddk_pkg::DIST_BITS-1:0]     distance,
  output logic                              saturated,
  output logic                              mode_error
);

  localparam int DB   = ddk_pkg::DIST_BITS;
  localparam int LR   = ddk_pkg::LOG_ROUNDS;
  localparam int ER   = ddk_pkg::EXP_ROUNDS;
  localparam int PB   = $clog2(RATIO_BITS);
  localparam int NS   = 6 + LR + ER;
  localparam logic [DB:0] DMAX = {1'b0, {DB{1'b1}}};
  localparam logic [ER*32-1:0] ROOTS = ddk_pkg::exp2_roots();

  typedef struct packed {
    logic [RATIO_BITS-1:0] ratio;
    logic                  zero;
    logic [PB-1:0]         p;
    logic [31:0]           m;
    logic [35:0]           l2;
    logic [37:0]           ln;
    logic [38:0]           y;
    logic [63:0]           rem;
    logic [63:0]           root;
    logic [37:0]           e;
    logic [31:0]           ex;
    logic [63:0]           lin;
    logic [DB:0]           dg;
    logic [DB:0]           df;
    logic                  fsat;
  } item_t;

  logic [ddk_pkg::MODE_BITS-1:0]  dispersal_mode;
  logic [ddk_pkg::SCALE_BITS-1:0] distance_scale;
  item_t st [NS];
  logic  vl [NS];
  logic  adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      dispersal_mode <= ddk_pkg::MODE_LINEAR;
      distance_scale <= ddk_pkg::SCALE_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        ddk_pkg::REG_MODE:  dispersal_mode <= cfg_data[ddk_pkg::MODE_BITS-1:0];
        ddk_pkg::REG_SCALE: distance_scale <= cfg_data[ddk_pkg::SCALE_BITS-1:0];
        default: ;
      endcase
    end
  end

  assign adv      = !out_valid || !out_stall;
  assign in_stall = !adv;

  // log2 mantissa squaring round
  function automatic item_t log_round(input item_t a);
    item_t b;
    logic [63:0] sq;
    begin
      b = a;
      sq = ({32'd0, a.m} * {32'd0, a.m}) >> 30;
      b.l2 = {a.l2[34:0], 1'b0};
      if (sq >= 64'(1) << 31) begin
        b.m = sq[32:1];
        b.l2[0] = 1'b1;
      end else begin
        b.m = sq[31:0];
      end
      return b;
    end
  endfunction

  // one bit of the square root, step k works on bit 62 - 2k
  function automatic item_t sqrt_step(input item_t a, input int k);
    item_t b;
    logic [63:0] bt;
    begin
      b = a;
      bt = 64'(1) << (62 - 2 * k);
      if (a.rem >= a.root + bt) begin
        b.rem = a.rem - (a.root + bt);
        b.root = (a.root >> 1) + bt;
      end else begin
        b.root = a.root >> 1;
      end
      return b;
    end
  endfunction

  function automatic logic [DB:0] clip(input logic [127:0] v);
    return (v > 128'(DMAX)) ? {1'b1, DMAX[DB-1:0]} : v[DB:0];
  endfunction

  // pipeline: 0 normalise, 1..LR log rounds, then l2 finalise, ln, sqrt start, exp rounds, finishing
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NS; i++) vl[i] <= 1'b0;
    end else if (adv) begin
      vl[0] <= in_valid;
      for (int i = 1; i < NS; i++) vl[i] <= vl[i-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      item_t t;
      logic [PB-1:0] pp;
      logic [127:0] big;
      int sh;
      // stage 0: leading one and mantissa
      t = '0;
      t.ratio = ratio;
      t.zero = (ratio == '0);
      pp = '0;
      for (int b = 0; b < RATIO_BITS; b++) if (ratio[b]) pp = PB'(b);
      t.p = pp;
      t.m = 32'(({32'd0, 32'(ratio)} << 30) >> pp);
      t.lin = ((64'(1) << RATIO_BITS) - 64'(ratio)) * 64'd2000;
      st[0] <= t;
      for (int i = 1; i <= LR; i++) st[i] <= log_round(st[i-1]);
      // l2 finalise
      t = st[LR];
      t.l2 = ((36'(RATIO_BITS) - 36'(t.p)) << 30) - {6'd0, t.l2[29:0]};
      st[LR+1] <= t;
      t = st[LR+1];
      t.ln = 38'((72'(t.l2) * 72'(ddk_pkg::LN2_Q28)) >> 28);
      t.e = 38'((38'(t.l2) * 38'd3) >> 1);
      t.ex = 32'd1 << 30;
      st[LR+2] <= t;
      // square root spread over the exp stages, first two steps here
      t = st[LR+2];
      t.rem = 64'({t.ln, 1'b0}) << 20;
      t.root = '0;
      t = sqrt_step(t, 0);
      t = sqrt_step(t, 1);
      st[LR+3] <= t;
      for (int i = 1; i <= ER; i++) begin
        t = st[LR+2+i];
        if (t.e[30-i]) t.ex = 32'((64'(t.ex) * 64'(ROOTS[(i-1)*32 +: 32])) >> 30);
        t = sqrt_step(t, i + 1);
        st[LR+3+i] <= t;
      end
      // finishing: fat tail part, then the mode-selected linear, exp, gaussian or comb part
      t = st[LR+3+ER];
      t.y = t.root[38:0];
      big = 128'(distance_scale) * 128'(t.ex);
      sh = int'(t.e[37:30]) + DIST_FRAC_BITS - 38;
      t.fsat = 1'b0;
      if (big == '0) t.df = '0;
      else if (sh >= 0) begin
        if (sh >= DB || big > (128'(DMAX) >> sh)) begin
          t.df = DMAX;
          t.fsat = 1'b1;
        end else t.df = clip(big << sh);
      end else t.df = clip(big >> (-sh));
      st[LR+4+ER] <= t;
      t = st[LR+4+ER];
      case (dispersal_mode)
        ddk_pkg::MODE_EXP:
          t.dg = clip((128'(t.ln) * 128'd125 * 128'(distance_scale)) >> (40 - DIST_FRAC_BITS));
        ddk_pkg::MODE_GAUSS:
          t.dg = clip((128'(t.y) * 128'd40 * 128'(distance_scale)) >> (33 - DIST_FRAC_BITS));
        ddk_pkg::MODE_COMB:
          t.dg = clip((128'(t.y) * 128'd5 * 128'(distance_scale)) >> (33 - DIST_FRAC_BITS));
        default:
          t.dg = clip(128'((64'((t.lin << DIST_FRAC_BITS) >> RATIO_BITS) *
                            64'(ddk_pkg::RECIP19)) >> ddk_pkg::RECIP19_SHIFT));
      endcase
      st[LR+5+ER] <= t;
    end
  end

  item_t   fin;
  logic [DB+1:0] sum;
  logic [DB-1:0] d_next;
  logic          s_next;
  logic          e_next;

  assign fin = st[NS-1];

  always_comb begin
    d_next = '0;
    s_next = 1'b0;
    e_next = 1'b0;
    sum = '0;
    case (dispersal_mode)
      ddk_pkg::MODE_LINEAR: begin
        d_next = fin.dg[DB-1:0];
        s_next = fin.dg[DB];
      end
      ddk_pkg::MODE_EXP, ddk_pkg::MODE_GAUSS: begin
        d_next = fin.dg[DB-1:0];
        s_next = fin.dg[DB];
      end
      ddk_pkg::MODE_FAT: begin
        d_next = fin.df[DB-1:0];
        s_next = fin.fsat || fin.df[DB];
      end
      ddk_pkg::MODE_COMB: begin
        sum = {1'b0, fin.dg} + {1'b0, fin.df};
        if (fin.fsat || sum > {1'b0, DMAX}) begin
          d_next = DMAX[DB-1:0];
          s_next = 1'b1;
        end else begin
          d_next = sum[DB-1:0];
        end
      end
      default: e_next = 1'b1;
    endcase
    if (fin.zero && !e_next && dispersal_mode != ddk_pkg::MODE_LINEAR) begin
      d_next = DMAX[DB-1:0];
      s_next = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= vl[NS-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      distance   <= d_next;
      saturated  <= s_next;
      mode_error <= e_next;
    end
  end

  `DDK_ASSERT_NEXT(a_hold, out_valid && out_stall, out_valid && $stable(distance), "stalled result changed")
  `DDK_ASSERT_IMPL(a_err_zero, out_valid && mode_error, distance == '0 && !saturated, "error with distance")
  `DDK_ASSERT_IMPL(a_sat_max, out_valid && saturated, &distance, "saturated below maximum")

endmodule
